@@ design/aic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aic_pkg;

   localparam int TABLE_DEPTH_DEF = 128;
   localparam logic [7:0] AGE_LIMIT_RST = 8'd10;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_RESOLVE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   localparam logic [1:0] STS_DONE = 2'd0;
   localparam logic [1:0] STS_MISS = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] mac;
      logic [7:0]  removed;
      logic [7:0]  entries;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ design/aic_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aic_table #(
   parameter int DEPTH = aic_pkg::TABLE_DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [PTR_W-1:0]    wr_addr,
   input  wire aic_pkg::entry_type  wr_data,
   input  wire logic                rd_en,
   input  wire logic [PTR_W-1:0]    rd_addr,
   output      aic_pkg::entry_type  rd_data
);
   import aic_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/aic_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aic_engine #(
   parameter int DEPTH = aic_pkg::TABLE_DEPTH_DEF,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [1:0]            req_cmd,
   input  wire logic [31:0]           req_address,
   input  wire logic [15:0]           req_mac_tail,
   input  wire logic [7:0]            age_limit,
   input  wire logic                  out_free,
   output      logic                  rsp_push,
   output      aic_pkg::rsp_word_type rsp_word,
   output      logic                  mem_we,
   output      logic [PTR_W-1:0]      mem_waddr,
   output      aic_pkg::entry_type    mem_wdata,
   output      logic                  mem_re,
   output      logic [PTR_W-1:0]      mem_raddr,
   input  wire aic_pkg::entry_type    mem_rdata
);
   import aic_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_START, S_SCAN, S_AGE, S_FINISH} state_type;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] s);
      return (s == '0) ? LAST_SLOT : s - PTR_W'(1);
   endfunction

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [31:0]      addr_ff, addr_in;
   logic [15:0]      tail_ff, tail_in;
   logic [PTR_W-1:0] oldest_ff, oldest_in;
   logic [PTR_W-1:0] newest_ff, newest_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [15:0]      tick_ff, tick_in;
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic [1:0]       status_ff, status_in;
   logic [47:0]      mac_ff, mac_in;
   logic [15:0]      age;

   assign req_stall = (state_ff != S_IDLE);
   assign mem_waddr = newest_ff;
   assign mem_wdata = '{ip: addr_ff, stamp: tick_ff};
   assign age       = tick_ff - mem_rdata.stamp;
   assign rsp_word  = '{status: status_ff, mac: mac_ff,
                        removed: 8'(removed_ff), entries: 8'(occ_ff)};

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      tail_in     = tail_ff;
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      occ_in      = occ_ff;
      tick_in     = tick_ff;
      scan_ptr_in = scan_ptr_ff;
      scan_cnt_in = scan_cnt_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      mac_in      = mac_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_raddr   = scan_ptr_ff;
      rsp_push    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               addr_in  = req_address;
               tail_in  = req_mac_tail;
               state_in = S_START;
            end
         end
         S_START: begin
            status_in   = STS_DONE;
            mac_in      = '0;
            removed_in  = '0;
            scan_cnt_in = '0;
            state_in    = S_FINISH;
            unique case (cmd_ff)
               CMD_INSERT: begin
                  if (occ_ff == FULL_CNT) begin
                     status_in = STS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     newest_in = next_slot(newest_ff);
                     occ_in    = occ_ff + CNT_W'(1);
                  end
               end
               CMD_RESOLVE: begin
                  if (occ_ff == '0) begin
                     status_in = STS_MISS;
                  end else begin
                     mem_re      = 1'b1;
                     mem_raddr   = prev_slot(newest_ff);
                     scan_ptr_in = prev_slot(newest_ff);
                     state_in    = S_SCAN;
                  end
               end
               CMD_TICK: begin
                  tick_in = tick_ff + 16'd1;
                  if (occ_ff != '0) begin
                     mem_re    = 1'b1;
                     mem_raddr = oldest_ff;
                     state_in  = S_AGE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (mem_rdata.ip == addr_ff) begin
               mac_in   = {addr_ff, tail_ff};
               state_in = S_FINISH;
            end else if (scan_cnt_ff + CNT_W'(1) == occ_ff) begin
               status_in = STS_MISS;
               state_in  = S_FINISH;
            end else begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
               mem_re      = 1'b1;
               mem_raddr   = prev_slot(scan_ptr_ff);
               scan_ptr_in = prev_slot(scan_ptr_ff);
            end
         end
         S_AGE: begin
            if (age >= {8'd0, age_limit}) begin
               oldest_in  = next_slot(oldest_ff);
               occ_in     = occ_ff - CNT_W'(1);
               removed_in = removed_ff + CNT_W'(1);
               if (occ_ff == CNT_W'(1)) begin
                  state_in = S_FINISH;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = next_slot(oldest_ff);
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      addr_ff     <= addr_in;
      tail_ff     <= tail_in;
      scan_ptr_ff <= scan_ptr_in;
      scan_cnt_ff <= scan_cnt_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
      mac_ff      <= mac_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         oldest_ff <= '0;
         newest_ff <= '0;
         occ_ff    <= '0;
         tick_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         occ_ff    <= occ_in;
         tick_ff   <= tick_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy beyond table depth");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(occ_ff) |-> (occ_ff == $past(occ_ff) + CNT_W'(1)) ||
                           (occ_ff == $past(occ_ff) - CNT_W'(1)))
      else $error("occupancy moved by more than one entry");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) || (state_ff == S_AGE) |-> occ_ff != '0)
      else $error("table walk with no entries held");

   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> state_ff == S_IDLE)
      else $error("engine busy after result push");

endmodule

`default_nettype wire

@@ design/aging_ip_mac_cache.sv @@
// Insert: the word passes through the START and FINISH states before its result is pushed, one item at a time.
// Resolve: entries compared newest first, one table read per cycle.
// Tick: entries examined from the oldest end, one table read per cycle.
// A finished word waits in the output register while the next item is taken.
// Synchronous active-high reset empties the table at once and sets age_limit to 10.
`timescale 1ns / 1ps
`default_nettype none

module aging_ip_mac_cache #(
   parameter int TABLE_DEPTH = aic_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_address,
   input  wire logic [15:0] req_mac_tail,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [47:0] rsp_mac_out,
   output      logic [7:0]  rsp_removed_count,
   output      logic [7:0]  rsp_entry_count,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_age_limit
);
   import aic_pkg::*;

   localparam int PTR_W = $clog2(TABLE_DEPTH);

   logic [7:0]       limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             out_free;
   logic             rsp_push;
   logic             mem_we;
   logic [PTR_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             mem_re;
   logic [PTR_W-1:0] mem_raddr;
   entry_type        mem_rdata;

   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_age_limit : limit_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = rsp_push || (rsp_valid_ff && rsp_stall);

   aic_engine #(
      .DEPTH(TABLE_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_address  (req_address),
      .req_mac_tail (req_mac_tail),
      .age_limit    (limit_ff),
      .out_free     (out_free),
      .rsp_push     (rsp_push),
      .rsp_word     (rsp_word_in),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata)
   );

   aic_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (reset) begin
         limit_ff     <= AGE_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_word_ff.status;
   assign rsp_mac_out       = rsp_word_ff.mac;
   assign rsp_removed_count = rsp_word_ff.removed;
   assign rsp_entry_count   = rsp_word_ff.entries;

endmodule

`default_nettype wire
